### rtl/brct_pkg.sv
// ----------------------------------------------------------------------------
// brct_pkg
// Shared types and constants for the ranked sparse child table.
// ----------------------------------------------------------------------------
package brct_pkg;

  // Fixed field widths of the transaction payload
  localparam int SLOT_W      = 6;   // slot_index, position, found_slot
  localparam int COUNT_W     = 7;   // occupied_count (0..64)

  // Defaults for the top-level parameters
  localparam int DEF_SLOTS   = 64;
  localparam int DEF_CHILD_W = 16;

  // Operation codes; the unused code is served like a lookup
  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIRST  = 3'd3,
    OP_LAST   = 3'd4,
    OP_NEXT   = 3'd5,
    OP_PREV   = 3'd6
  } op_t;

  // Where the reported child comes from
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_MEM   = 2'd1,
    SRC_INPUT = 2'd2
  } child_src_t;

  // Decision of the rank/search stage for one transaction
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] position;
    logic [SLOT_W-1:0] found_slot;
    logic              status;
    logic              wr_en;     // store child_node at slot_index
    logic              inc;       // one more occupied slot
    logic              dec;       // one less occupied slot
    child_src_t        child_src;
  } rank_res_t;

endpackage

### rtl/brct_mem.sv
// ----------------------------------------------------------------------------
// brct_mem
// Child store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brct_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/brct_rank.sv
// ----------------------------------------------------------------------------
// brct_rank
// Bitmap logic: slot search, rank count and occupancy update.
// ----------------------------------------------------------------------------
module brct_rank
  import brct_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic [2:0]        operation,
  input  logic [SLOT_W-1:0] slot_index,
  input  logic [SLOTS-1:0]  map,
  output logic [SLOTS-1:0]  map_next,
  output rank_res_t         res
);

  op_t               op;
  logic              is_search;
  logic              in_range;
  logic              was;
  logic              found;
  logic [SLOTS-1:0]  sel;
  logic [SLOTS-1:0]  above;
  logic [SLOTS-1:0]  below_slot;
  logic [SLOTS-1:0]  cand;
  logic [SLOTS-1:0]  below_s;
  logic [SLOT_W-1:0] lo;
  logic [SLOT_W-1:0] hi;
  logic [SLOT_W-1:0] s;
  logic [COUNT_W-1:0] rank;

  assign op        = op_t'(operation);
  assign is_search = (op == OP_FIRST) || (op == OP_LAST) || (op == OP_NEXT) || (op == OP_PREV);
  assign in_range  = {1'b0, slot_index} < COUNT_W'(SLOTS);

  // slot decode against the reference slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      sel[i]        = (slot_index == SLOT_W'(i));
      above[i]      = (SLOT_W'(i) > slot_index);
      below_slot[i] = (SLOT_W'(i) < slot_index);
    end
  end

  assign was = in_range && (|(map & sel));

  // candidate slots; next and previous are strict
  always_comb begin
    case (op)
      OP_FIRST, OP_LAST: cand = map;
      OP_NEXT:           cand = map & above;
      OP_PREV:           cand = map & below_slot;
      default:           cand = '0;
    endcase
  end

  assign found = |cand;

  // priority encoders, lowest and highest set bit
  always_comb begin
    lo = '0;
    hi = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) lo = SLOT_W'(i);
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (cand[i]) hi = SLOT_W'(i);
    end
  end

  always_comb begin
    if (!is_search) s = slot_index;
    else if ((op == OP_FIRST) || (op == OP_NEXT)) s = lo;
    else s = hi;
  end

  // rank = occupied slots below s
  always_comb begin
    rank = '0;
    for (int i = 0; i < SLOTS; i++) begin
      below_s[i] = (SLOT_W'(i) < s);
    end
    for (int i = 0; i < SLOTS; i++) begin
      rank = rank + COUNT_W'(map[i] & below_s[i]);
    end
  end

  always_comb begin
    res           = '0;
    res.child_src = SRC_ZERO;
    map_next      = map;
    if (is_search) begin
      if (found) begin
        res.hit        = 1'b1;
        res.position   = rank[SLOT_W-1:0];
        res.found_slot = s;
        res.child_src  = SRC_MEM;
      end
      res.status = !found;
    end else if (in_range) begin
      res.hit        = was;
      res.position   = rank[SLOT_W-1:0];
      res.found_slot = slot_index;
      if (op == OP_INSERT) begin
        res.wr_en     = 1'b1;
        res.inc       = !was;
        res.child_src = SRC_INPUT;
        res.status    = 1'b0;
        map_next      = map | sel;
      end else if (was) begin
        res.child_src = SRC_MEM;
        res.status    = 1'b0;
        if (op == OP_REMOVE) begin
          res.dec  = 1'b1;
          map_next = map & ~sel;
        end
      end else begin
        res.status = 1'b1;
      end
    end else begin
      res.status = 1'b1;
    end
  end

endmodule

### rtl/bitmap_ranked_child_table.sv
// ----------------------------------------------------------------------------
// bitmap_ranked_child_table
// Sparse child table of one trie node: occupancy bitmap plus a slot-indexed
// child memory, with lookup, insert, remove, first, last, next and previous.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------
//  request  req_valid / req_ready  operation, slot_index, child_node
//  response rsp_valid / rsp_ready  hit, position, found_slot, found_child,
//                                  occupied_count, status
//
//  Timing: a response is valid in the cycle after its request transaction;
//    the registered read port of the child memory sets that delay.
//    One transaction per cycle is sustained while responses are taken.
//  Reset: clears the bitmap, the occupied count and rsp_valid. The child
//    memory is not cleared; an entry is only reported while its bit is set.
//  Stalls: req_ready drops while a response waits untaken.
//
module bitmap_ranked_child_table
  import brct_pkg::*;
#(
  parameter int SLOTS          = DEF_SLOTS,
  parameter int CHILD_ID_WIDTH = DEF_CHILD_W
) (
  input  logic                      clk,
  input  logic                      rst,
  // request
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic [2:0]                operation,
  input  logic [SLOT_W-1:0]         slot_index,
  input  logic [CHILD_ID_WIDTH-1:0] child_node,
  // response
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      hit,
  output logic [SLOT_W-1:0]         position,
  output logic [SLOT_W-1:0]         found_slot,
  output logic [CHILD_ID_WIDTH-1:0] found_child,
  output logic [COUNT_W-1:0]        occupied_count,
  output logic                      status
);

  localparam int AW = $clog2(SLOTS);

  logic                      accept;
  logic [SLOTS-1:0]          map;
  logic [SLOTS-1:0]          map_next;
  logic [COUNT_W-1:0]        occupied_next;
  rank_res_t                 res;
  child_src_t                child_src;
  logic [CHILD_ID_WIDTH-1:0] child_in;   // child_node of the last accepted request
  logic [CHILD_ID_WIDTH-1:0] rd_data;

  // A new request may enter whenever the response register frees up at this
  // edge. The memory write of an insert lands before any later read, so no
  // forwarding is needed.
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // bitmap decode, search and rank
  brct_rank #(
    .SLOTS (SLOTS)
  ) u_rank (
    .operation  (operation),
    .slot_index (slot_index),
    .map        (map),
    .map_next   (map_next),
    .res        (res)
  );

  // child store; the read addresses the reported slot
  brct_mem #(
    .DEPTH (SLOTS),
    .WIDTH (CHILD_ID_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && res.wr_en),
    .wr_addr (slot_index[AW-1:0]),
    .wr_data (child_node),
    .rd_en   (accept),
    .rd_addr (res.found_slot[AW-1:0]),
    .rd_data (rd_data)
  );

  // running count avoids a second popcount
  assign occupied_next = occupied_count + COUNT_W'(res.inc) - COUNT_W'(res.dec);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      map            <= '0;
      occupied_count <= '0;
      rsp_valid      <= 1'b0;
    end else if (accept) begin
      map            <= map_next;
      occupied_count <= occupied_next;
      rsp_valid      <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid      <= 1'b0;
    end
  end

  // response payload; held while the response is stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= res.hit;
      position   <= res.position;
      found_slot <= res.found_slot;
      status     <= res.status;
      child_src  <= res.child_src;
      child_in   <= child_node;
    end
  end

  // memory data is used straight from the read register
  always_comb begin
    case (child_src)
      SRC_MEM:   found_child = rd_data;
      SRC_INPUT: found_child = child_in;
      default:   found_child = '0;
    endcase
  end

`ifndef ASSERT_OFF
  // running count tracks the bitmap
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    occupied_count == COUNT_W'($countones(map)))
    else $error("occupied count out of step with bitmap");

  // every request yields a response on the next cycle
  a_rsp_follows_req: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("response missing after request");

  // memory read register must hold while a response is stalled
  a_child_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(found_child)))
    else $error("found_child changed during stall");
`endif

endmodule
